@@ hw/rtl/pps_pkg.sv @@
// Package for the preemptive priority scheduler.
// Holds the table depth, the entry layout and the result kinds; no dependencies.
package pps_pkg;

  localparam int READY_DEPTH = 16;
  localparam int IDX_W       = $clog2(READY_DEPTH);
  localparam int CNT_W       = $clog2(READY_DEPTH + 1);

  localparam int KEY_W  = 46;
  localparam int LEN_W  = 32;
  localparam int RESP_W = 33;
  localparam int ENTRY_W = KEY_W + LEN_W + RESP_W;

  localparam logic       OP_ARRIVE = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  localparam logic [1:0] KIND_PREEMPT = 2'd0;
  localparam logic [1:0] KIND_FINISH  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // One table entry: rank key, burst lengths and response word.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  lengths;
    logic [RESP_W-1:0] resp;
  } entry_t;

  // Time counter step that sticks at the top value.
  function automatic logic [31:0] sat_inc(input logic [31:0] t);
    sat_inc = (&t) ? t : t + 32'd1;
  endfunction

  // Clamp a 32-bit length to 16 bits.
  function automatic logic [15:0] clamp16(input logic [31:0] v);
    clamp16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

@@ hw/rtl/pps_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg and pps_ram.
//
// Usage: the in_ channel carries arrive items (operation 0) and tick items
// (operation 1). An arrive gives no result unless the ready table is full,
// when one rejected record follows. A tick scans the ready table one entry
// per cycle through one key comparator and the RAM read port, then decides;
// with nothing to run it ends there. Otherwise it runs the job, after a
// dispatch or preemption step when a new job takes over, and a finish goes
// on through a compute state and then an output state.
// A tick gives up to two records on the out_ channel: a preempted slice
// and a finished slice; last marks the final one.
// in_stall is high while an item is at work or a record waits in the output
// register; a stall on out_ holds the record and the block until taken.
// After reset the time is 0, the table is empty and no job runs; the table
// RAM needs no clearing since per-entry valid bits guard it.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_process_id,
  input  logic signed [5:0] in_nice_level,
  input  logic [15:0] in_burst_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_job_id,
  output logic [31:0] out_slice_start,
  output logic [15:0] out_slice_length,
  output logic [31:0] out_completion_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic [31:0] out_response,
  output logic        out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_DISP, S_RUN, S_FIN1, S_FIN2
  } state_t;

  localparam logic [pps_pkg::CNT_W-1:0] CNT_END = pps_pkg::CNT_W'(pps_pkg::READY_DEPTH);

  state_t state_r;
  logic [31:0] time_r;
  logic [pps_pkg::READY_DEPTH-1:0] valid_r;
  logic [pps_pkg::CNT_W-1:0] cnt_r;
  logic rd_pend_r;
  logic [pps_pkg::IDX_W-1:0] rd_idx_r;
  logic best_v_r;
  logic [pps_pkg::IDX_W-1:0] best_idx_r;
  pps_pkg::entry_t best_r;
  logic run_v_r;
  pps_pkg::entry_t run_r;
  logic [31:0] slice_start_r;
  logic [31:0] comp_r, ta_r, sl_r;

  logic out_valid_r;
  logic [1:0] kind_r;
  logic [7:0] job_r;
  logic [31:0] o_start_r, o_comp_r, o_ta_r, o_wait_r, o_resp_r;
  logic [15:0] o_len_r;
  logic last_r;

  logic in_fire, out_free;
  logic ram_we;
  logic [pps_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
  pps_pkg::entry_t ram_wdata, ram_rdata;
  logic free_found;
  logic [pps_pkg::IDX_W-1:0] free_idx;
  logic [31:0] run_len;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign run_len  = time_r - slice_start_r;

  // Lowest free table slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pps_pkg::READY_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = pps_pkg::IDX_W'(i);
      end
    end
  end

  // Table write port: arrivals fill a free slot, preemption swaps back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = run_r;
    ram_raddr = cnt_r[pps_pkg::IDX_W-1:0];
    if (state_r == S_IDLE && in_fire && in_operation == pps_pkg::OP_ARRIVE && free_found) begin
      ram_we = 1'b1;
      ram_wdata.key = {~in_nice_level[5], in_nice_level[4:0], time_r, in_process_id};
      ram_wdata.lengths = {in_burst_length, in_burst_length};
      ram_wdata.resp = '0;
    end else if (state_r == S_DECIDE && run_v_r && best_v_r && best_r.key < run_r.key) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
    end
  end

  pps_ram #(.WIDTH(pps_pkg::ENTRY_W), .DEPTH(pps_pkg::READY_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, scheduler state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      best_v_r    <= 1'b0;
      run_v_r     <= 1'b0;
      run_r       <= '0;
      slice_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_operation == pps_pkg::OP_ARRIVE) begin
              if (free_found) begin
                valid_r[free_idx] <= 1'b1;
              end else begin
                out_valid_r <= 1'b1;
                kind_r    <= pps_pkg::KIND_REJECT;
                job_r     <= in_process_id;
                o_start_r <= '0;
                o_len_r   <= '0;
                o_comp_r  <= '0;
                o_ta_r    <= '0;
                o_wait_r  <= '0;
                o_resp_r  <= '0;
                last_r    <= 1'b1;
              end
            end else begin
              cnt_r     <= '0;
              rd_pend_r <= 1'b0;
              best_v_r  <= 1'b0;
              state_r   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one read per cycle and compare the entry read before.
          rd_pend_r <= (cnt_r != CNT_END);
          rd_idx_r  <= cnt_r[pps_pkg::IDX_W-1:0];
          if (cnt_r != CNT_END) begin
            cnt_r <= cnt_r + pps_pkg::CNT_W'(1);
          end
          if (rd_pend_r && valid_r[rd_idx_r] && (!best_v_r || ram_rdata.key < best_r.key)) begin
            best_v_r   <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_r     <= ram_rdata;
          end
          if (cnt_r == CNT_END && !rd_pend_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!run_v_r && !best_v_r) begin
            time_r  <= pps_pkg::sat_inc(time_r);
            state_r <= S_IDLE;
          end else if (run_v_r && best_v_r && best_r.key < run_r.key) begin
            // Preempt: the running job goes back into the best job's slot.
            if (run_len != 32'd0) begin
              out_valid_r <= 1'b1;
              kind_r    <= pps_pkg::KIND_PREEMPT;
              job_r     <= run_r.key[7:0];
              o_start_r <= slice_start_r;
              o_len_r   <= pps_pkg::clamp16(run_len);
              o_comp_r  <= '0;
              o_ta_r    <= '0;
              o_wait_r  <= '0;
              o_resp_r  <= '0;
              last_r    <= (best_r.lengths[15:1] != 15'd0);
            end
            run_r   <= best_r;
            state_r <= S_DISP;
          end else if (!run_v_r && best_v_r) begin
            run_r   <= best_r;
            run_v_r <= 1'b1;
            valid_r[best_idx_r] <= 1'b0;
            state_r <= S_DISP;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_DISP: begin
          // First dispatch fixes the response time.
          slice_start_r <= time_r;
          if (!run_r.resp[32]) begin
            run_r.resp <= {1'b1, time_r - run_r.key[39:8]};
          end
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (run_r.lengths[15:0] > 16'd1) begin
            run_r.lengths[15:0] <= run_r.lengths[15:0] - 16'd1;
            time_r  <= pps_pkg::sat_inc(time_r);
            state_r <= S_IDLE;
          end else begin
            run_r.lengths[15:0] <= '0;
            comp_r  <= pps_pkg::sat_inc(time_r);
            state_r <= S_FIN1;
          end
        end
        S_FIN1: begin
          ta_r    <= comp_r - run_r.key[39:8];
          sl_r    <= comp_r - slice_start_r;
          state_r <= S_FIN2;
        end
        default: begin
          // Finished record, once the output register is free.
          if (out_free) begin
            out_valid_r <= 1'b1;
            kind_r    <= pps_pkg::KIND_FINISH;
            job_r     <= run_r.key[7:0];
            o_start_r <= slice_start_r;
            o_len_r   <= pps_pkg::clamp16(sl_r);
            o_comp_r  <= comp_r;
            o_ta_r    <= ta_r;
            o_wait_r  <= (ta_r >= {16'd0, run_r.lengths[31:16]}) ?
                         ta_r - {16'd0, run_r.lengths[31:16]} : 32'd0;
            o_resp_r  <= run_r.resp[31:0];
            last_r    <= 1'b1;
            run_v_r   <= 1'b0;
            time_r    <= pps_pkg::sat_inc(time_r);
            state_r   <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_job_id          = job_r;
  assign out_slice_start     = o_start_r;
  assign out_slice_length    = o_len_r;
  assign out_completion_time = o_comp_r;
  assign out_turnaround      = o_ta_r;
  assign out_waiting         = o_wait_r;
  assign out_response        = o_resp_r;
  assign out_last            = last_r;

endmodule
